FILE: hdl/s20x_pkg.sv
// ----------------------------------------------------------------------------
// s20x_pkg
// Shared types, constants and round functions for the Salsa20 keystream core.
// ----------------------------------------------------------------------------
package s20x_pkg;

    localparam int S20X_ROUNDS = 20;
    localparam int S20X_IDX_W  = 3;
    localparam int S20X_CFG_W  = 64;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    typedef enum logic [S20X_IDX_W-1:0] {
        REG_KEY_Q0 = 3'd0,
        REG_KEY_Q1 = 3'd1,
        REG_KEY_Q2 = 3'd2,
        REG_KEY_Q3 = 3'd3,
        REG_NONCE  = 3'd4
    } t_reg_idx;

    typedef logic [15:0][31:0] t_words;
    typedef logic [3:0][31:0]  t_quad;

    typedef struct packed {
        logic start;
        logic abort;
    } t_gen_req;

    function automatic logic [31:0] f_rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_quad f_qr(t_quad q);
        t_quad o;
        o = q;
        o[1] = o[1] ^ f_rotl(o[0] + o[3], 7);
        o[2] = o[2] ^ f_rotl(o[1] + o[0], 9);
        o[3] = o[3] ^ f_rotl(o[2] + o[1], 13);
        o[0] = o[0] ^ f_rotl(o[3] + o[2], 18);
        return o;
    endfunction

    // column pass when row is low, row pass otherwise
    function automatic t_words f_pass(t_words w, logic row);
        t_words o;
        t_quad  q0;
        t_quad  q1;
        t_quad  q2;
        t_quad  q3;
        o = w;
        if (!row) begin
            q0 = f_qr({w[12], w[8], w[4], w[0]});
            q1 = f_qr({w[1], w[13], w[9], w[5]});
            q2 = f_qr({w[6], w[2], w[14], w[10]});
            q3 = f_qr({w[11], w[7], w[3], w[15]});
            {o[12], o[8], o[4], o[0]}   = q0;
            {o[1], o[13], o[9], o[5]}   = q1;
            {o[6], o[2], o[14], o[10]}  = q2;
            {o[11], o[7], o[3], o[15]}  = q3;
        end else begin
            q0 = f_qr({w[3], w[2], w[1], w[0]});
            q1 = f_qr({w[4], w[7], w[6], w[5]});
            q2 = f_qr({w[9], w[8], w[11], w[10]});
            q3 = f_qr({w[14], w[13], w[12], w[15]});
            {o[3], o[2], o[1], o[0]}     = q0;
            {o[4], o[7], o[6], o[5]}     = q1;
            {o[9], o[8], o[11], o[10]}   = q2;
            {o[14], o[13], o[12], o[15]} = q3;
        end
        return o;
    endfunction

endpackage

FILE: hdl/s20x_in_if.sv
// ----------------------------------------------------------------------------
// s20x_in_if
// Message byte channel.
// ----------------------------------------------------------------------------
interface s20x_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: hdl/s20x_out_if.sv
// ----------------------------------------------------------------------------
// s20x_out_if
// Result byte channel.
// ----------------------------------------------------------------------------
interface s20x_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       result_last;

    modport source (output valid, output result_byte, output result_last, input ready);
    modport sink (input valid, input result_byte, input result_last, output ready);
endinterface

FILE: hdl/s20x_fifo.sv
// ----------------------------------------------------------------------------
// s20x_fifo
// Two-entry front queue holding accepted message beats.
// ----------------------------------------------------------------------------
module s20x_fifo
    import s20x_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [8:0] i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [8:0] o_data
);
    logic [1:0][8:0] r_mem;
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: hdl/s20x_kgen.sv
// ----------------------------------------------------------------------------
// s20x_kgen
// Keystream block generator: one round per cycle, then the feedforward add.
// ----------------------------------------------------------------------------
module s20x_kgen
    import s20x_pkg::*;
#(
    parameter int ROUND_COUNT = S20X_ROUNDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_gen_req     i_req,
    input  logic [255:0] i_key,
    input  logic [63:0]  i_nonce,
    input  logic [63:0]  i_ctr,
    output logic         o_busy,
    output logic         o_done,
    output t_words       o_words
);
    localparam int RW = $clog2(ROUND_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_gstate;

    t_gstate       r_state;
    logic [RW-1:0] r_rnd;
    t_words        r_w;
    t_words        r_init;
    t_words        init_w;

    always_comb begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = i_key[31:0];
        init_w[2]  = i_key[63:32];
        init_w[3]  = i_key[95:64];
        init_w[4]  = i_key[127:96];
        init_w[5]  = SIGMA_1;
        init_w[6]  = i_nonce[31:0];
        init_w[7]  = i_nonce[63:32];
        init_w[8]  = i_ctr[31:0];
        init_w[9]  = i_ctr[63:32];
        init_w[10] = SIGMA_2;
        init_w[11] = i_key[159:128];
        init_w[12] = i_key[191:160];
        init_w[13] = i_key[223:192];
        init_w[14] = i_key[255:224];
        init_w[15] = SIGMA_3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
        end else if (i_req.abort) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= S_RUN;
                        r_rnd   <= '0;
                    end
                end
                S_RUN: begin
                    r_rnd <= r_rnd + RW'(1);
                    if (r_rnd == RW'(ROUND_COUNT - 1)) r_state <= S_FIN;
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.start) begin
            r_w    <= init_w;
            r_init <= init_w;
        end else if (r_state == S_RUN) begin
            r_w <= f_pass(r_w, r_rnd[0]);
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) o_words[i] = r_w[i] + r_init[i];
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN) && !i_req.abort;
endmodule

FILE: hdl/salsa20_stream_xor_core.sv
// ----------------------------------------------------------------------------
// salsa20_stream_xor_core
// Salsa20 stream XOR, one message beat in and one result beat out per cycle
// unless keystream is not ready or the result side holds back. A front queue
// takes message beats; the back end XORs each with the next keystream byte
// into an output register. The generator runs one round per cycle and works
// one 64-byte block ahead, so a steady stream moves at one beat per cycle.
// After a beat marked last, after reset, or after a configuration write, the
// next block is rebuilt and the first beat of it waits for the generator.
// ----------------------------------------------------------------------------
module salsa20_stream_xor_core
    import s20x_pkg::*;
#(
    parameter int ROUND_COUNT = S20X_ROUNDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [S20X_IDX_W-1:0] i_cfg_idx,
    input  logic [S20X_CFG_W-1:0] i_cfg_data,
    s20x_in_if.sink               i_in,
    s20x_out_if.source            o_out
);
    logic [255:0] r_key;
    logic [63:0]  r_nonce;
    logic [63:0]  r_ctr;
    logic [5:0]   r_pos;
    logic         r_cur_valid;
    logic         r_next_valid;
    t_words       r_cur;
    t_words       r_next;
    logic         r_ov;
    logic [7:0]   r_obyte;
    logic         r_olast;

    logic         q_full;
    logic         q_empty;
    logic [8:0]   q_data;
    logic         fire;
    logic         flush;
    logic         blk_end;
    logic         n_cur_valid;
    logic         n_next_valid;
    logic         move_next;
    t_gen_req     gen_req;
    logic         gen_busy;
    logic         gen_done;
    t_words       gen_words;
    logic [7:0]   ks_byte;

    assign i_in.ready = !q_full;

    s20x_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid && !q_full),
        .i_data  ({i_in.end_of_message, i_in.data_byte}),
        .o_full  (q_full),
        .i_pop   (fire),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign fire    = !q_empty && r_cur_valid && (!r_ov || o_out.ready);
    assign blk_end = fire && (q_data[8] || r_pos == 6'd63);
    assign flush   = i_cfg_we || (fire && q_data[8]);
    assign ks_byte = r_cur[r_pos[5:2]][r_pos[1:0]*8 +: 8];

    assign gen_req.abort = flush;
    assign gen_req.start = !gen_busy && !flush && (!r_cur_valid || !r_next_valid);

    s20x_kgen #(.ROUND_COUNT(ROUND_COUNT)) u_kgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gen_req),
        .i_key   (r_key),
        .i_nonce (r_nonce),
        .i_ctr   (r_cur_valid ? r_ctr + 64'd1 : r_ctr),
        .o_busy  (gen_busy),
        .o_done  (gen_done),
        .o_words (gen_words)
    );

    always_comb begin
        n_cur_valid  = r_cur_valid;
        n_next_valid = r_next_valid;
        move_next    = 1'b0;
        if (blk_end) begin
            move_next    = !q_data[8] && r_next_valid;
            n_cur_valid  = move_next;
            n_next_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_next_valid = 1'b0;
            if (r_pos == 6'd0) n_cur_valid = 1'b0;
        end
        if (gen_done) begin
            if (!n_cur_valid) n_cur_valid = 1'b1;
            else n_next_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_nonce      <= '0;
            r_ctr        <= '0;
            r_pos        <= '0;
            r_cur_valid  <= 1'b0;
            r_next_valid <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_cur_valid  <= n_cur_valid;
            r_next_valid <= n_next_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_Q0: r_key[63:0]    <= i_cfg_data;
                    REG_KEY_Q1: r_key[127:64]  <= i_cfg_data;
                    REG_KEY_Q2: r_key[191:128] <= i_cfg_data;
                    REG_KEY_Q3: r_key[255:192] <= i_cfg_data;
                    REG_NONCE:  r_nonce        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (fire) begin
                r_ov <= 1'b1;
                if (q_data[8]) begin
                    r_ctr <= '0;
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_ctr <= r_ctr + 64'd1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_obyte <= q_data[7:0] ^ ks_byte;
            r_olast <= q_data[8];
        end
        if (move_next) r_cur <= r_next;
        if (gen_done) begin
            if (!(blk_end ? move_next : (r_cur_valid && !(i_cfg_we && r_pos == 6'd0))))
                r_cur <= gen_words;
            else
                r_next <= gen_words;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.result_byte = r_obyte;
    assign o_out.result_last = r_olast;

    a_next_implies_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_valid |-> r_cur_valid) else $error("next block held without current block");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && q_data[8]) |=> (r_pos == 6'd0 && r_ctr == 64'd0 && !r_cur_valid))
        else $error("message end did not restart the stream");

    a_cfg_drops_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_next_valid) else $error("stale look-ahead block kept after write");
endmodule

FILE: bench/s20x_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20x_checker
// Watches the message and result channels, keeps its own Salsa20 keystream
// state and key/nonce copy, and compares every result beat in order.
// ----------------------------------------------------------------------------
module s20x_checker
    import s20x_pkg::*;
#(
    parameter int ROUND_COUNT = S20X_ROUNDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [S20X_IDX_W-1:0] i_cfg_idx,
    input  logic [S20X_CFG_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [7:0]            i_out_byte,
    input  logic                  i_out_last,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last;
    } t_result;

    logic [63:0]       key_q [4];
    logic [63:0]       nonce_q;
    logic [63:0]       blk_ctr;
    logic [5:0]        byte_pos;
    logic [15:0][31:0] ks_words;
    t_result           expected_q [$];

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix(ref logic [31:0] w [16], input int a, int b, int c, int d);
        w[b] = w[b] ^ rotl32(w[a] + w[d], 7);
        w[c] = w[c] ^ rotl32(w[b] + w[a], 9);
        w[d] = w[d] ^ rotl32(w[c] + w[b], 13);
        w[a] = w[a] ^ rotl32(w[d] + w[c], 18);
    endfunction

    function automatic logic [15:0][31:0] salsa_block();
        logic [31:0]       init [16];
        logic [31:0]       w [16];
        logic [15:0][31:0] res;
        init = '{SIGMA_0, key_q[0][31:0], key_q[0][63:32], key_q[1][31:0],
                 key_q[1][63:32], SIGMA_1, nonce_q[31:0], nonce_q[63:32],
                 blk_ctr[31:0], blk_ctr[63:32], SIGMA_2, key_q[2][31:0],
                 key_q[2][63:32], key_q[3][31:0], key_q[3][63:32], SIGMA_3};
        w = init;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            if (r % 2 == 0) begin
                mix(w, 0, 4, 8, 12);
                mix(w, 5, 9, 13, 1);
                mix(w, 10, 14, 2, 6);
                mix(w, 15, 3, 7, 11);
            end else begin
                mix(w, 0, 1, 2, 3);
                mix(w, 5, 6, 7, 4);
                mix(w, 10, 11, 8, 9);
                mix(w, 15, 12, 13, 14);
            end
        end
        for (int i = 0; i < 16; i++) res[i] = w[i] + init[i];
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result           e;
        logic [15:0][31:0] ks;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_q[i] = '0;
            nonce_q  = '0;
            blk_ctr  = '0;
            byte_pos = '0;
            ks_words = '0;
            o_errors = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result beat %h last %b", i_out_byte, i_out_last);
                end else begin
                    e = expected_q.pop_front();
                    if (e.cipher_byte !== i_out_byte || e.last !== i_out_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                     e.cipher_byte, e.last, i_out_byte, i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (byte_pos == 0) ks_words = salsa_block();
                ks = ks_words;
                e.cipher_byte = i_in_byte ^ ks[byte_pos[5:2]][byte_pos[1:0]*8 +: 8];
                e.last        = i_in_last;
                expected_q.push_back(e);
                if (i_in_last) begin
                    blk_ctr  = '0;
                    byte_pos = '0;
                end else begin
                    if (byte_pos == 6'd63) blk_ctr = blk_ctr + 64'd1;
                    byte_pos = byte_pos + 6'd1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_Q0: key_q[0] = i_cfg_data;
                    REG_KEY_Q1: key_q[1] = i_cfg_data;
                    REG_KEY_Q2: key_q[2] = i_cfg_data;
                    REG_KEY_Q3: key_q[3] = i_cfg_data;
                    REG_NONCE:  nonce_q  = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/tb_salsa20_stream_xor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_salsa20_stream_xor_core
// Drives message beats with random gaps and result back-pressure through
// several key/nonce settings; the checker predicts and compares each beat.
// ----------------------------------------------------------------------------
module tb_salsa20_stream_xor_core;
    import s20x_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [S20X_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
    localparam logic [S20X_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [S20X_IDX_W-1:0] i_cfg_idx;
    logic [S20X_CFG_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    idle_cycles;

    s20x_in_if  msg_if ();
    s20x_out_if res_if ();

    salsa20_stream_xor_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (msg_if.sink),
        .o_out      (res_if.source)
    );

    s20x_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (msg_if.valid),
        .i_in_ready  (msg_if.ready),
        .i_in_byte   (msg_if.data_byte),
        .i_in_last   (msg_if.end_of_message),
        .i_out_valid (res_if.valid),
        .i_out_ready (res_if.ready),
        .i_out_byte  (res_if.result_byte),
        .i_out_last  (res_if.result_last),
        .o_errors    (fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output back-pressure
    initial begin
        int gap;
        res_if.ready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            repeat (gap) @(posedge i_clk) res_if.ready <= 1'b0;
            @(posedge i_clk) res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            res_if.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("salsa20_stream_xor_core verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= b;
        msg_if.end_of_message <= last;
        do @(posedge i_clk); while (!msg_if.ready);
    endtask

    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (S20X_ROUNDS + 8) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [S20X_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_key_nonce(input logic [63:0] k0, k1, k2, k3, n);
        write_reg(REG_KEY_Q0, k0);
        write_reg(REG_KEY_Q1, k1);
        write_reg(REG_KEY_Q2, k2);
        write_reg(REG_KEY_Q3, k3);
        write_reg(REG_NONCE, n);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(input int len, input bit burst);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1, burst);
    endtask

    initial begin
        int len;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = '0;
        msg_if.end_of_message = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero key, extreme bytes, single-beat message, last flag
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h5a, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b1, 1'b0);
        wait_drained();

        // all ones key and nonce, ignored index
        load_key_nonce('1, '1, '1, '1, '1);
        write_reg(IDX_UNUSED_HI, 64'h0123_4567_89ab_cdef);
        write_reg(IDX_UNUSED_LO, '1);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        wait_drained();

        // cross two block boundaries back to back, then a random-gap span
        load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64());
        send_message(140, 1'b1);
        send_message(70, 1'b0);
        wait_drained();

        // random settings and message lengths
        for (int phase = 0; phase < 5; phase++) begin
            load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64());
            for (int m = 0; m < 5; m++) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 12);
                send_message(len, $urandom_range(0, 2) == 0);
            end
            // short closing message
            send_message($urandom_range(1, 5), 1'b0);
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0)
            $display("salsa20_stream_xor_core verification clean");
        else
            $display("salsa20_stream_xor_core verification failed");
        $finish;
    end

endmodule

FILE: salsa20_stream_xor_core.f
hdl/s20x_pkg.sv
hdl/s20x_in_if.sv
hdl/s20x_out_if.sv
hdl/s20x_fifo.sv
hdl/s20x_kgen.sv
hdl/salsa20_stream_xor_core.sv
bench/s20x_checker.sv
bench/tb_salsa20_stream_xor_core.sv
